@@ src/tce_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the text console.
// No dependencies; imported by every module of the console.
package tce_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int ADDR_W  = $clog2(CELLS);
   localparam int SWEEP_W = $clog2(CELLS + COLUMNS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);

   // Transaction field widths
   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int RCOL_W    = 7;
   localparam int RROW_W    = 5;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = 16;
   localparam int CUR_COL_W = 7;
   localparam int CUR_ROW_W = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Character codes with special handling
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

   localparam int              TAB_STEP   = 4;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep_step;
      logic load_cr;
      logic load_final;
   } tce_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_lf;
      logic            need_scroll;
      logic            sweep_last;
      logic            out_free;
   } tce_sts_type;

endpackage

@@ src/tce_ctrl.sv @@
// Controller state machine for the text console: sequences execute, sweep and result loads.
// Depends on tce_pkg for command/status types and operation codes.
module tce_ctrl import tce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output tce_cmd_type cmd,
   input  tce_sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_EXEC    = 5'b00010,
      S_SWEEP   = 5'b00100,
      S_EMIT_CR = 5'b01000,
      S_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.op == OP_CLEAR) begin
               state_in = S_SWEEP;
            end else if (sts.op == OP_PUT && sts.need_scroll) begin
               state_in = S_SWEEP;
            end else if (sts.op == OP_PUT && sts.is_lf) begin
               state_in = S_EMIT_CR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = (sts.op == OP_PUT && sts.is_lf) ? S_EMIT_CR : S_EMIT;
            end
         end
         S_EMIT_CR: begin
            if (sts.out_free) begin
               cmd.load_cr = 1'b1;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/tce_datapath.sv @@
// Datapath for the text console: screen memory, cursor, sweep counter and result register.
// Depends on tce_pkg for geometry, codes and command/status types.
module tce_datapath import tce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  tce_cmd_type          cmd,
   output tce_sts_type          sts,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [RCOL_W-1:0]    req_read_col,
   input  logic [RROW_W-1:0]    req_read_row,
   input  logic                 csr_we,
   input  logic [ATTR_W-1:0]    csr_text_attr,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_serial_valid,
   output logic [CHAR_W-1:0]    rsp_serial_byte,
   output logic [CELL_W-1:0]    rsp_cell_value,
   output logic [CUR_COL_W-1:0] rsp_cursor_col,
   output logic [CUR_ROW_W-1:0] rsp_cursor_row,
   output logic                 rsp_last
);

   logic [CELL_W-1:0] screen_mem [CELLS];

   // Captured transaction
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [RCOL_W-1:0] rc_ff, rc_in;
   logic [RROW_W-1:0] rr_ff, rr_in;

   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [SWEEP_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic               scroll_mode_ff, scroll_mode_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [ADDR_W-1:0]  pipe_addr_ff, pipe_addr_in;
   logic               pipe_fill_ff, pipe_fill_in;
   logic               oor_ff, oor_in;
   logic [CELL_W-1:0]  rd_data_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 sv_ff, sv_in;
   logic [CHAR_W-1:0]    sb_ff, sb_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;
   logic [CUR_COL_W-1:0] ccol_ff, ccol_in;
   logic [CUR_ROW_W-1:0] crow_ff, crow_in;
   logic                 last_ff, last_in;

   // Cursor update for a put
   logic [COL_W:0]    ncol;
   logic [ROW_W:0]    nrow;
   logic [COL_W-1:0]  wcol;
   logic              put_we;
   logic [CHAR_W-1:0] put_char;
   logic              need_scroll;
   logic              in_range;
   logic              sweep_last;
   logic [SWEEP_W-1:0] sweep_end;

   // Memory ports
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [CELL_W-1:0] blank_cell;
   logic              out_free;
   logic              put_exec_we;

   assign blank_cell = {attr_ff, CH_BLANK};
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ncol     = {1'b0, col_ff};
      nrow     = {1'b0, row_ff};
      wcol     = col_ff;
      put_we   = 1'b0;
      put_char = ch_ff;
      unique case (ch_ff)
         CH_LF: begin
            ncol = '0;
            nrow = {1'b0, row_ff} + 1'b1;
         end
         CH_CR: ncol = '0;
         CH_BS: begin
            if (col_ff != '0) begin
               ncol     = {1'b0, col_ff} - 1'b1;
               wcol     = col_ff - 1'b1;
               put_we   = 1'b1;
               put_char = CH_BLANK;
            end
         end
         CH_TAB: begin
            ncol = ({1'b0, col_ff} + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
         end
         default: begin
            ncol   = {1'b0, col_ff} + 1'b1;
            put_we = 1'b1;
         end
      endcase
      if (ncol >= (COL_W+1)'(COLUMNS)) begin
         ncol = '0;
         nrow = nrow + 1'b1;
      end
      need_scroll = (nrow >= (ROW_W+1)'(ROWS));
      if (need_scroll) nrow = (ROW_W+1)'(ROWS - 1);
   end

   assign in_range   = (32'(rc_ff) < 32'(COLUMNS)) && (32'(rr_ff) < 32'(ROWS));
   assign sweep_end  = scroll_mode_ff ? SWEEP_W'(CELLS + COLUMNS - 1) : SWEEP_W'(CELLS - 1);
   assign sweep_last = (sweep_cnt_ff == sweep_end);
   assign put_exec_we = cmd.exec && (op_ff == OP_PUT) && put_we;

   // Memory port selection: sweep writes go through a one-stage pipe behind the read
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pipe_addr_ff;
      mem_wdata = pipe_fill_ff ? blank_cell : rd_data_ff;
      mem_re    = 1'b0;
      mem_raddr = ADDR_W'(rr_ff) * ADDR_W'(COLUMNS) + ADDR_W'(rc_ff);
      if (pipe_vld_ff) begin
         mem_we = 1'b1;
      end else if (put_exec_we) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(wcol);
         mem_wdata = {attr_ff, put_char};
      end
      if (cmd.exec && op_ff == OP_READ && in_range) begin
         mem_re = 1'b1;
      end else if (cmd.sweep_step && scroll_mode_ff && sweep_cnt_ff < SWEEP_W'(CELLS)) begin
         mem_re    = 1'b1;
         mem_raddr = sweep_cnt_ff[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) screen_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= screen_mem[mem_raddr];
   end

   // Next-state logic
   always_comb begin
      op_in          = op_ff;
      ch_in          = ch_ff;
      rc_in          = rc_ff;
      rr_in          = rr_ff;
      attr_in        = csr_we ? csr_text_attr : attr_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      scroll_mode_in = scroll_mode_ff;
      pipe_vld_in    = 1'b0;
      pipe_addr_in   = pipe_addr_ff;
      pipe_fill_in   = pipe_fill_ff;
      oor_in         = oor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      sv_in          = sv_ff;
      sb_in          = sb_ff;
      cell_in        = cell_ff;
      ccol_in        = ccol_ff;
      crow_in        = crow_ff;
      last_in        = last_ff;

      if (cmd.capture) begin
         op_in = req_op;
         ch_in = req_char_code;
         rc_in = req_read_col;
         rr_in = req_read_row;
      end

      if (cmd.exec) begin
         oor_in = !in_range;
         if (op_ff == OP_PUT) begin
            col_in         = ncol[COL_W-1:0];
            row_in         = nrow[ROW_W-1:0];
            sweep_cnt_in   = SWEEP_W'(COLUMNS);
            scroll_mode_in = 1'b1;
         end else if (op_ff == OP_CLEAR) begin
            col_in         = '0;
            row_in         = '0;
            sweep_cnt_in   = '0;
            scroll_mode_in = 1'b0;
         end
      end

      if (cmd.sweep_step) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         pipe_vld_in  = 1'b1;
         if (scroll_mode_ff) begin
            pipe_addr_in = ADDR_W'(sweep_cnt_ff - SWEEP_W'(COLUMNS));
            pipe_fill_in = (sweep_cnt_ff >= SWEEP_W'(CELLS));
         end else begin
            pipe_addr_in = sweep_cnt_ff[ADDR_W-1:0];
            pipe_fill_in = 1'b1;
         end
      end

      if (cmd.load_cr || cmd.load_final) begin
         rsp_valid_in = 1'b1;
         ccol_in      = CUR_COL_W'(col_ff);
         crow_in      = CUR_ROW_W'(row_ff);
         cell_in      = '0;
         if (cmd.load_cr) begin
            sv_in   = 1'b1;
            sb_in   = CH_CR;
            last_in = 1'b0;
         end else begin
            last_in = 1'b1;
            sv_in   = (op_ff == OP_PUT);
            sb_in   = (op_ff == OP_PUT) ? ch_ff : '0;
            if (op_ff == OP_READ && !oor_ff) cell_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff        <= ATTR_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         sweep_cnt_ff   <= '0;
         scroll_mode_ff <= 1'b0;
         pipe_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         attr_ff        <= attr_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         scroll_mode_ff <= scroll_mode_in;
         pipe_vld_ff    <= pipe_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      rc_ff        <= rc_in;
      rr_ff        <= rr_in;
      pipe_addr_ff <= pipe_addr_in;
      pipe_fill_ff <= pipe_fill_in;
      oor_ff       <= oor_in;
      sv_ff        <= sv_in;
      sb_ff        <= sb_in;
      cell_ff      <= cell_in;
      ccol_ff      <= ccol_in;
      crow_ff      <= crow_in;
      last_ff      <= last_in;
   end

   assign sts.op          = op_ff;
   assign sts.is_lf       = (ch_ff == CH_LF);
   assign sts.need_scroll = need_scroll;
   assign sts.sweep_last  = sweep_last;
   assign sts.out_free    = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_serial_valid = sv_ff;
   assign rsp_serial_byte  = sb_ff;
   assign rsp_cell_value   = cell_ff;
   assign rsp_cursor_col   = ccol_ff;
   assign rsp_cursor_row   = crow_ff;
   assign rsp_last         = last_ff;

`ifndef NO_ASSERTIONS
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(pipe_vld_ff && put_exec_we))
      else $error("sweep write and put write in the same cycle");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor outside the screen");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_cr || cmd.load_final) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result is still pending");

   a_sweep_in_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (sweep_cnt_ff <= sweep_end))
      else $error("sweep counter ran past its end");
`endif

endmodule

@@ src/text_console_engine_top.sv @@
// Top level of the text console: controller, datapath and configuration register port.
// Depends on tce_pkg, tce_ctrl and tce_datapath.
//
//  channel  | ports                                   | direction | accepted when
//  ---------+-----------------------------------------+-----------+-----------------------
//  request  | req_valid/req_ready, op, char, col, row | in        | req_valid & req_ready
//  response | rsp_valid/rsp_ready, six result fields  | out       | rsp_valid & rsp_ready
//  csr      | csr_valid/csr_ready, csr_text_attr      | in        | csr_valid & csr_ready
//
// A line feed also emits a CR result ahead of its own result; the next request is taken
// once the final result is loaded. Clear and scroll-up run a sweep over the screen memory,
// one cell per cycle through its single read and single write port.
// Synchronous active-high reset clears cursor, attribute (0x0F) and control; screen
// contents stay undefined until cleared or written.
// A stalled response holds in the output register; the block waits in place until it drains.
module text_console_engine_top import tce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [RCOL_W-1:0]    req_read_col,
   input  logic [RROW_W-1:0]    req_read_row,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_serial_valid,
   output logic [CHAR_W-1:0]    rsp_serial_byte,
   output logic [CELL_W-1:0]    rsp_cell_value,
   output logic [CUR_COL_W-1:0] rsp_cursor_col,
   output logic [CUR_ROW_W-1:0] rsp_cursor_row,
   output logic                 rsp_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ATTR_W-1:0]    csr_text_attr
);

   tce_cmd_type cmd;
   tce_sts_type sts;
   logic        csr_we;

   // The attribute register takes a write in any cycle; software writes it only while idle.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // Sequence each transaction: capture, execute, optional sweep, then result loads.
   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Hold screen, cursor and the response register; advance on controller commands, attribute on csr writes.
   tce_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_read_col     (req_read_col),
      .req_read_row     (req_read_row),
      .csr_we           (csr_we),
      .csr_text_attr    (csr_text_attr),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_serial_valid (rsp_serial_valid),
      .rsp_serial_byte  (rsp_serial_byte),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_last         (rsp_last)
   );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for text_console_engine_top: screen, cursor, serial mirror, reads.
// Depends on tce_pkg and the console RTL; a scoreboard class predicts every response.
`timescale 1ns / 100ps

module testbench;
   import tce_pkg::*;

   // Op code the block must ignore (not part of the package)
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT     = 20_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 600;
   localparam int unsigned REPORT_LIMIT    = 40;
   localparam int unsigned PHASE_ITEMS     = 350;

   // One response transaction, field order as on the rsp_ ports
   typedef struct packed {
      logic                 serial_valid;
      logic [CHAR_W-1:0]    serial_byte;
      logic [CELL_W-1:0]    cell_value;
      logic [CUR_COL_W-1:0] cursor_col;
      logic [CUR_ROW_W-1:0] cursor_row;
      logic                 last;
   } console_result_type;

   // Mirror of the console: keeps its own screen, cursor and attribute, and holds the
   // responses still owed by the block, oldest first.
   class console_scoreboard_type;
      logic [CELL_W-1:0]  screen [CELLS];
      int unsigned        cur_col;
      int unsigned        cur_row;
      logic [ATTR_W-1:0]  attr;
      console_result_type awaited[$];
      int unsigned        errors;

      function new();
         cur_col = 0;
         cur_row = 0;
         attr    = ATTR_RESET;
         errors  = 0;
      endfunction

      function void set_attr(logic [ATTR_W-1:0] value);
         attr = value;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      // Queue a response; the cursor fields always show the cursor after the whole item
      function void owe_result(logic serial_valid, logic [CHAR_W-1:0] serial_byte,
                               logic [CELL_W-1:0] cell_word, logic last);
         console_result_type r;
         r.serial_valid = serial_valid;
         r.serial_byte  = serial_byte;
         r.cell_value   = cell_word;
         r.cursor_col   = CUR_COL_W'(cur_col);
         r.cursor_row   = CUR_ROW_W'(cur_row);
         r.last         = last;
         awaited.push_back(r);
      endfunction

      function void roll_screen_up();
         for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[ADDR_W'(i)] = screen[ADDR_W'(i + COLUMNS)];
         for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[ADDR_W'(i)] = {attr, CH_BLANK};
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                                 logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
         logic [CELL_W-1:0] cell_word;
         case (op)
            OP_PUT: begin
               case (code)
                  CH_LF: begin
                     cur_col = 0;
                     cur_row++;
                  end
                  CH_CR: cur_col = 0;
                  CH_BS: begin
                     if (cur_col > 0) begin
                        cur_col--;
                        screen[ADDR_W'(cur_row * COLUMNS + cur_col)] = {attr, CH_BLANK};
                     end
                  end
                  CH_TAB: cur_col = (cur_col + TAB_STEP) / TAB_STEP * TAB_STEP;
                  default: begin
                     screen[ADDR_W'(cur_row * COLUMNS + cur_col)] = {attr, code};
                     cur_col++;
                  end
               endcase
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  cur_row++;
               end
               if (cur_row >= ROWS) begin
                  roll_screen_up();
                  cur_row = ROWS - 1;
               end
               if (code == CH_LF)
                  owe_result(1'b1, CH_CR, '0, 1'b0);
               owe_result(1'b1, code, '0, 1'b1);
            end
            OP_READ: begin
               cell_word = '0;
               if (rcol < COLUMNS && rrow < ROWS)
                  cell_word = screen[ADDR_W'(rrow * COLUMNS + rcol)];
               owe_result(1'b0, '0, cell_word, 1'b1);
            end
            OP_CLEAR: begin
               for (int i = 0; i < CELLS; i++)
                  screen[ADDR_W'(i)] = {attr, CH_BLANK};
               cur_col = 0;
               cur_row = 0;
               owe_result(1'b0, '0, '0, 1'b1);
            end
            default: owe_result(1'b0, '0, '0, 1'b1);
         endcase
      endfunction

      function void check_field(string field, logic [CELL_W-1:0] want,
                                logic [CELL_W-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(console_result_type got);
         console_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: response with nothing outstanding, actual %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         check_field("serial_valid", CELL_W'(want.serial_valid), CELL_W'(got.serial_valid));
         check_field("serial_byte", CELL_W'(want.serial_byte), CELL_W'(got.serial_byte));
         check_field("cell_value", want.cell_value, got.cell_value);
         check_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(got.cursor_col));
         check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
         check_field("last", CELL_W'(want.last), CELL_W'(got.last));
      endfunction
   endclass

   // Every input starts at a known value
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op        = OP_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [RCOL_W-1:0]    req_read_col  = '0;
   logic [RROW_W-1:0]    req_read_row  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic                 rsp_serial_valid;
   logic [CHAR_W-1:0]    rsp_serial_byte;
   logic [CELL_W-1:0]    rsp_cell_value;
   logic [CUR_COL_W-1:0] rsp_cursor_col;
   logic [CUR_ROW_W-1:0] rsp_cursor_row;
   logic                 rsp_last;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [ATTR_W-1:0]    csr_text_attr = '0;

   console_scoreboard_type mirror = new();

   // Idle and stall odds in percent, set per phase by the main sequence
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   // Bumped by the main sequence to ask the receiver for one long hold-off
   int unsigned hold_requests = 0;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;

   text_console_engine_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_read_col     (req_read_col),
      .req_read_row     (req_read_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_serial_valid (rsp_serial_valid),
      .rsp_serial_byte  (rsp_serial_byte),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_text_attr    (csr_text_attr)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: sized for a sweep on every item plus stalls, far above a normal run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // Receiver: check each response transaction on the edge it is taken, then pick the
   // next ready value. A hold-off request drops ready for a long counted stretch so the
   // block backs up and stalls its request side.
   initial begin
      int unsigned        hold_left;
      int unsigned        hold_seen;
      console_result_type seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen = {rsp_serial_valid, rsp_serial_byte, rsp_cell_value,
                    rsp_cursor_col, rsp_cursor_row, rsp_last};
            mirror.check_result(seen);
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one request transaction and hold it until taken; idle first at the phase odds.
   // Valid is only lowered when an idle cycle really follows, so a back-to-back
   // transaction keeps valid high through the edge.
   task automatic send_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                               logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_char_code <= code;
      req_read_col  <= rcol;
      req_read_row  <= rrow;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(op, code, rcol, rrow);
      items_sent++;
   endtask

   // Unused fields of a put carry random junk
   task automatic send_put(logic [CHAR_W-1:0] code);
      send_request(OP_PUT, code, RCOL_W'($urandom), RROW_W'($urandom));
   endtask

   task automatic send_read(int unsigned col, int unsigned row);
      send_request(OP_READ, CHAR_W'($urandom), RCOL_W'(col), RROW_W'(row));
   endtask

   // Mostly printable text, now and then any byte at all
   function automatic logic [CHAR_W-1:0] random_glyph();
      if ($urandom_range(99) < 15)
         return CHAR_W'($urandom);
      return CHAR_W'($urandom_range(8'h7E, 8'h20));
   endfunction

   // Text body character with a sprinkling of the control codes
   function automatic logic [CHAR_W-1:0] text_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5)
         return CH_BS;
      if (pick < 10)
         return CH_TAB;
      if (pick < 13)
         return CH_CR;
      if (pick < 15)
         return CH_LF;
      return random_glyph();
   endfunction

   // Register write; only called with nothing outstanding
   task automatic write_attr(logic [ATTR_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_text_attr <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror.set_attr(value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.outstanding() != 0)
         @(posedge clock);
   endtask

   // Random traffic shaped as console use: short text lines mostly ending in a line feed keep the
   // cursor marching down into scroll-up, long unbroken runs force wraps (tab wraps too),
   // read bursts look often at the cursor row, with a little noise and the odd clear.
   task automatic send_random_traffic(int unsigned count);
      int unsigned target;
      int unsigned pick;
      int unsigned len;
      int unsigned col;
      int unsigned row;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = $urandom_range(30);
            repeat (len) send_put(text_char());
            pick = $urandom_range(9);
            if (pick >= 6 && pick < 8)
               send_put(CH_CR);
            if (pick < 8)
               send_put(CH_LF);
         end else if (pick < 78) begin
            len = $urandom_range(170, 70);
            repeat (len) begin
               pick = $urandom_range(99);
               if (pick < 10)
                  send_put(CH_TAB);
               else if (pick < 15)
                  send_put(CH_BS);
               else
                  send_put(random_glyph());
            end
         end else if (pick < 93) begin
            len = $urandom_range(8, 1);
            repeat (len) begin
               pick = $urandom_range(99);
               if (pick < 5) begin
                  col = $urandom_range(127, COLUMNS);
                  row = $urandom_range(31);
               end else if (pick < 10) begin
                  col = $urandom_range(127);
                  row = $urandom_range(31, ROWS);
               end else if (pick < 55) begin
                  col = $urandom_range(COLUMNS - 1);
                  row = mirror.cur_row;
               end else begin
                  col = $urandom_range(COLUMNS - 1);
                  row = $urandom_range(ROWS - 1);
               end
               send_read(col, row);
            end
         end else if (pick < 98) begin
            send_request(OP_UNUSED, CHAR_W'($urandom), RCOL_W'($urandom), RROW_W'($urandom));
         end else begin
            send_request(OP_CLEAR, CHAR_W'($urandom), RCOL_W'($urandom), RROW_W'($urandom));
         end
      end
   endtask

   // Main sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset attribute. Clear first: the screen holds nothing
      // defined until then, so no read may come earlier.
      send_request(OP_CLEAR, 8'hFF, '1, '1);
      send_read(0, 0);
      send_put(8'h41);
      send_put(8'hFF);
      send_put(8'h00);
      // Backspace blanks the cell it steps back onto
      send_put(CH_BS);
      send_read(2, 0);
      send_read(1, 0);
      // Carriage return, then backspace at column zero changes nothing
      send_put(CH_CR);
      send_put(CH_BS);
      send_put(CH_TAB);
      send_put(CH_TAB);
      // Line feed: CR response first, then LF
      send_put(CH_LF);
      // Corners of the screen and reads out of range
      send_read(COLUMNS - 1, ROWS - 1);
      send_read(COLUMNS, 0);
      send_read(0, ROWS);
      send_read(127, 31);
      // Unused op: ignored, cursor reported unchanged
      send_request(OP_UNUSED, 8'hFF, '1, '1);
      send_request(OP_UNUSED, 8'h00, '0, '0);
      send_read(0, 0);
      drain();

      // Back to back on both sides, attribute all zero
      write_attr(8'h00);
      send_random_traffic(PHASE_ITEMS);
      drain();

      // Sender idles, attribute all ones
      write_attr(8'hFF);
      req_idle_pct = 45;
      send_random_traffic(PHASE_ITEMS);
      drain();

      // Receiver stalls
      write_attr(ATTR_W'($urandom));
      req_idle_pct  = 0;
      rsp_stall_pct = 45;
      send_random_traffic(PHASE_ITEMS);
      drain();

      // Both sides idle
      write_attr(ATTR_W'($urandom));
      req_idle_pct  = 31;
      rsp_stall_pct = 31;
      send_random_traffic(PHASE_ITEMS);
      drain();

      // Back-pressure: receiver holds off for a long stretch while requests keep coming
      write_attr(ATTR_W'($urandom));
      req_idle_pct  = 0;
      rsp_stall_pct = 20;
      hold_requests <= hold_requests + 1;
      send_random_traffic(PHASE_ITEMS / 2);
      hold_requests <= hold_requests + 1;
      send_random_traffic(PHASE_ITEMS / 2);
      drain();

      // Let any stray response show up before the verdict
      repeat (50) @(posedge clock);
      if (mirror.errors == 0 && mirror.outstanding() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
